### src/srb_pkg.sv
package srb_pkg;

  // Default geometry of the block.
  localparam int CHANNELS_DEF = 4;
  localparam int WINDOW_DEF   = 32;

  // Field widths.
  localparam int CHAN_W    = 2;
  localparam int SEQ_W     = 32;
  localparam int PAY_W     = 64;
  localparam int STATUS_W  = 2;
  localparam int MINB_W    = 6;
  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 1;

  // Stream data width: chan, seq and payload packed, padded to whole bytes.
  localparam int FIELDS_W = CHAN_W + SEQ_W + PAY_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  // Depth of the result queue in front of the output port.
  localparam int OUT_DEPTH = 4;

  // Register reset values.
  localparam logic [MINB_W-1:0] MIN_BATCH_RST = 6'd4;
  localparam logic [SEQ_W-1:0]  FIRST_SEQ_RST = 32'd1;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_MIN_BATCH = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_SEQ = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED = 2'd0,
    ST_STALE    = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  // One result item.
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  payload;
    logic              last;
    status_t           status;
  } result_t;

endpackage

### src/srb_chan_mem.sv
module srb_chan_mem #(
  parameter int DEPTH = srb_pkg::CHANNELS_DEF,
  parameter int WIDTH = 69
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  clear,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data,
  output logic                                  rd_valid,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // An entry that has not been written since reset or the last clear reads
  // as invalid, and the user substitutes its reset contents.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

### src/srb_pay_mem.sv
module srb_pay_mem #(
  parameter int DEPTH = srb_pkg::CHANNELS_DEF * srb_pkg::WINDOW_DEF,
  parameter int WIDTH = srb_pkg::PAY_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/srb_out_fifo.sv
module srb_out_fifo (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  input  srb_pkg::result_t                          push_data,
  output logic [$clog2(srb_pkg::OUT_DEPTH + 1)-1:0] count,
  output logic                                      full,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output srb_pkg::result_t                          out_data
);
  import srb_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t       entries [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          pop;

  assign out_valid = (count != '0);
  assign full      = (count == CNT_W'(OUT_DEPTH));
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### src/sequence_reorder_batcher.sv
// A rejected item's status result is pushed into the result queue from the load state
// that follows its acceptance. A held item takes the block through accept, channel
// memory read and insert, and run count, and no new item is taken until it is done; a
// release then streams one result per cycle out of the payload memory while the output
// accepts results, limited by its single read port and the four-entry result queue.
// Reset clears control state and marks every channel as fresh; no clearing pass is run.
module sequence_reorder_batcher #(
  parameter int CHANNELS = srb_pkg::CHANNELS_DEF,
  parameter int WINDOW   = srb_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items. tdata, from bit 0: chan[1:0], seq_num[33:2], payload[97:34], zero pad.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [srb_pkg::TDATA_W-1:0]     s_axis_tdata,
  // Result items. tdata, from bit 0: out_chan[1:0], out_seq[33:2], out_payload[97:34],
  // zero pad. tuser: status[1:0]. tlast carries batch_last.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [srb_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic [srb_pkg::STATUS_W-1:0]    m_axis_tuser,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [srb_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [srb_pkg::CFG_W-1:0]       cfg_data
);
  import srb_pkg::*;

  // Channel index, window offset and run length widths.
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OW    = $clog2(WINDOW);
  localparam int RW    = $clog2(WINDOW + 1);
  localparam int SLOTS = CHANNELS * WINDOW;
  localparam int AW    = $clog2(SLOTS);
  // A channel memory word holds the expected number, the present map and the
  // ring head that says where offset zero lives in the channel's payload slots.
  localparam int CSW   = SEQ_W + WINDOW + OW;
  localparam int NW    = RW + 1;
  localparam int QW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_COUNT,
    S_RELEASE,
    S_FLUSH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [MINB_W-1:0] min_batch;
  logic [SEQ_W-1:0]  first_seq;

  // The item in work.
  logic [CHAN_W-1:0] item_chan;
  logic [SEQ_W-1:0]  item_seq;
  logic [PAY_W-1:0]  item_payload;
  logic [CW-1:0]     item_idx;
  logic              item_chan_ok;

  // Working copy of the channel state.
  logic [SEQ_W-1:0]  cur_next;
  logic [WINDOW-1:0] cur_present;
  logic [OW-1:0]     cur_head;
  logic [RW-1:0]     run;

  // Release sweep: read issue index and the read that is in flight.
  logic [RW-1:0]     rel_idx;
  logic              pend;
  logic [RW-1:0]     pend_idx;

  // Memory ports.
  logic              cm_rd_en;
  logic [CW-1:0]     cm_rd_addr;
  logic [CSW-1:0]    cm_rd_data;
  logic              cm_rd_valid;
  logic              cm_wr_en;
  logic [CSW-1:0]    cm_wr_data;
  logic              cm_clear;
  logic              pm_wr_en;
  logic [AW-1:0]     pm_wr_addr;
  logic              pm_rd_en;
  logic [AW-1:0]     pm_rd_addr;
  logic [PAY_W-1:0]  pm_rd_data;

  // Result queue.
  logic              q_push;
  result_t           q_data;
  logic [QW-1:0]     q_count;
  logic              q_full;
  result_t           q_out;

  // Combinational helpers.
  logic              in_accept;
  logic [7:0]        chan_ext;
  logic [SEQ_W-1:0]  ld_next;
  logic [WINDOW-1:0] ld_present;
  logic [OW-1:0]     ld_head;
  logic [SEQ_W-1:0]  ld_off;
  logic [OW:0]       ld_slot_sum;
  logic [OW-1:0]     ld_slot;
  logic [AW-1:0]     chan_base;
  logic [RW-1:0]     run_c;
  logic [6:0]        need;
  logic              run_ok;
  logic              credit_ok;
  logic              issue;
  logic              issue_last;
  logic [NW-1:0]     rel_sum;
  logic [OW-1:0]     rel_slot;
  logic [NW-1:0]     head_sum;
  logic [OW-1:0]     head_new;

  srb_chan_mem #(
    .DEPTH (CHANNELS),
    .WIDTH (CSW)
  ) u_chan_mem (
    .clk      (clk),
    .rst      (rst),
    .clear    (cm_clear),
    .rd_en    (cm_rd_en),
    .rd_addr  (cm_rd_addr),
    .rd_data  (cm_rd_data),
    .rd_valid (cm_rd_valid),
    .wr_en    (cm_wr_en),
    .wr_addr  (item_idx),
    .wr_data  (cm_wr_data)
  );

  srb_pay_mem #(
    .DEPTH (SLOTS),
    .WIDTH (PAY_W)
  ) u_pay_mem (
    .clk     (clk),
    .wr_en   (pm_wr_en),
    .wr_addr (pm_wr_addr),
    .wr_data (item_payload),
    .rd_en   (pm_rd_en),
    .rd_addr (pm_rd_addr),
    .rd_data (pm_rd_data)
  );

  srb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .count     (q_count),
    .full      (q_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (q_out)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, q_out.payload, q_out.seq, q_out.chan};
  assign m_axis_tlast = q_out.last;
  assign m_axis_tuser = q_out.status;

  // A new item is taken only with the block idle and room for a status result.
  assign s_axis_tready = (state == S_IDLE) && !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign chan_ext   = {{(8 - CHAN_W){1'b0}}, s_axis_tdata[CHAN_W-1:0]};
  assign cm_rd_en   = in_accept;
  assign cm_rd_addr = chan_ext[CW-1:0];
  assign cm_clear   = cfg_we && (cfg_index == REG_FIRST_SEQ);

  // A channel never written since reset or a restart holds its reset state.
  assign ld_next    = cm_rd_valid ? cm_rd_data[CSW-1 -: SEQ_W] : first_seq;
  assign ld_present = cm_rd_valid ? cm_rd_data[OW +: WINDOW] : '0;
  assign ld_head    = cm_rd_valid ? cm_rd_data[OW-1:0] : '0;

  // Offset from the expected number, modulo 2^32; its top bit marks stale items.
  assign ld_off      = item_seq - ld_next;
  assign ld_slot_sum = {1'b0, ld_head} + {1'b0, ld_off[OW-1:0]};
  assign ld_slot     = (ld_slot_sum >= (OW + 1)'(WINDOW)) ?
                       OW'(ld_slot_sum - (OW + 1)'(WINDOW)) : ld_slot_sum[OW-1:0];
  assign chan_base   = AW'(item_idx) * AW'(WINDOW);

  // Length of the unbroken run of present items from offset zero.
  always_comb begin
    run_c = RW'(WINDOW);
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!cur_present[i]) begin
        run_c = RW'(i);
      end
    end
  end

  // Batch threshold: zero counts as one, and it saturates at the window size.
  always_comb begin
    if (min_batch == '0) begin
      need = 7'd1;
    end else if ({1'b0, min_batch} > 7'(WINDOW)) begin
      need = 7'(WINDOW);
    end else begin
      need = {1'b0, min_batch};
    end
  end
  assign run_ok = (8'(run_c) >= {1'b0, need});

  // A payload read is issued only when the queue is sure to have room for it,
  // counting the read already in flight.
  assign credit_ok  = ((NW + 1)'(q_count) + (NW + 1)'(pend)) < (NW + 1)'(OUT_DEPTH);
  assign issue      = (state == S_RELEASE) && (rel_idx < run) && credit_ok;
  assign issue_last = issue && ((rel_idx + 1'b1) == run);

  assign rel_sum  = NW'(cur_head) + NW'(rel_idx);
  assign rel_slot = (rel_sum >= NW'(WINDOW)) ? OW'(rel_sum - NW'(WINDOW)) : OW'(rel_sum);
  assign head_sum = NW'(cur_head) + NW'(run);
  assign head_new = (head_sum >= NW'(WINDOW)) ? OW'(head_sum - NW'(WINDOW)) : OW'(head_sum);

  assign pm_rd_en   = issue;
  assign pm_rd_addr = chan_base + AW'(rel_slot);
  assign pm_wr_addr = chan_base + AW'(ld_slot);

  // Memory writes and queue pushes of the current state.
  always_comb begin
    pm_wr_en   = 1'b0;
    cm_wr_en   = 1'b0;
    cm_wr_data = {cur_next, cur_present, cur_head};
    q_push     = 1'b0;
    q_data     = '{chan: item_chan, seq: item_seq, payload: '0, last: 1'b1,
                   status: ST_BEYOND};
    case (state)
      S_LOAD: begin
        if (!item_chan_ok) begin
          q_push = 1'b1;
        end else if (ld_off[SEQ_W-1]) begin
          q_push        = 1'b1;
          q_data.status = ST_STALE;
        end else if (ld_off >= SEQ_W'(WINDOW)) begin
          q_push = 1'b1;
        end else if (ld_present[ld_off[OW-1:0]]) begin
          q_push        = 1'b1;
          q_data.status = ST_DUP;
        end else begin
          pm_wr_en = 1'b1;
        end
      end
      S_COUNT: begin
        // Held without a release: only the present map changed.
        cm_wr_en = !run_ok;
      end
      S_RELEASE, S_FLUSH: begin
        // The window slides past the run once its last read is issued.
        cm_wr_en   = issue_last;
        cm_wr_data = {cur_next + SEQ_W'(run), cur_present >> run, head_new};
        q_push     = pend;
        q_data     = '{chan: item_chan, seq: cur_next + SEQ_W'(pend_idx),
                       payload: pm_rd_data, last: ((pend_idx + 1'b1) == run),
                       status: ST_RELEASED};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_batch <= MIN_BATCH_RST;
      first_seq <= FIRST_SEQ_RST;
      pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_BATCH: min_batch <= cfg_data[MINB_W-1:0];
          REG_FIRST_SEQ: first_seq <= cfg_data[SEQ_W-1:0];
          default: begin
          end
        endcase
      end

      pend <= issue;

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= q_push ? S_IDLE : S_COUNT;
        end
        S_COUNT: begin
          state <= run_ok ? S_RELEASE : S_IDLE;
        end
        S_RELEASE: begin
          if (issue_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // The last payload read lands in the queue this cycle.
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item and working registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_chan    <= s_axis_tdata[CHAN_W-1:0];
      item_seq     <= s_axis_tdata[CHAN_W +: SEQ_W];
      item_payload <= s_axis_tdata[CHAN_W + SEQ_W +: PAY_W];
      item_idx     <= chan_ext[CW-1:0];
      item_chan_ok <= (chan_ext < 8'(CHANNELS));
    end
    if (state == S_LOAD) begin
      cur_next    <= ld_next;
      cur_present <= ld_present | (WINDOW'(1) << ld_off[OW-1:0]);
      cur_head    <= ld_head;
    end
    if (state == S_COUNT) begin
      run     <= run_c;
      rel_idx <= '0;
    end
    if (issue) begin
      rel_idx  <= rel_idx + 1'b1;
      pend_idx <= rel_idx;
    end
  end

endmodule
